@@ hw/rtl/dci_pkg.sv @@
// Shared payload types and register codes for the distance constraint impulse block.
package dci_pkg;

  typedef struct packed {
    logic signed [31:0] anchor_a_x;
    logic signed [31:0] anchor_a_y;
    logic signed [31:0] anchor_a_z;
    logic signed [31:0] anchor_b_x;
    logic signed [31:0] anchor_b_y;
    logic signed [31:0] anchor_b_z;
    logic signed [31:0] vel_in_a_x;
    logic signed [31:0] vel_in_a_y;
    logic signed [31:0] vel_in_a_z;
    logic signed [31:0] vel_in_b_x;
    logic signed [31:0] vel_in_b_y;
    logic signed [31:0] vel_in_b_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vel_out_a_x;
    logic signed [31:0] vel_out_a_y;
    logic signed [31:0] vel_out_a_z;
    logic signed [31:0] vel_out_b_x;
    logic signed [31:0] vel_out_b_y;
    logic signed [31:0] vel_out_b_z;
    logic               degenerate;
  } result_t;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_A  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_B  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 4'd3;

  localparam logic [31:0] RST_INV_MASS  = 32'd65536;
  localparam logic [30:0] RST_REST_LEN  = 31'd65536;
  localparam logic [31:0] RST_TIME_STEP = 32'd1092;

  localparam logic [40:0] DELTA_CAP = 41'd1 << 40;

endpackage

@@ hw/rtl/distance_constraint_impulse_core.sv @@
// Top level: pipelined distance constraint velocity impulse with output skid register.
//
// Use: items enter on item/item_valid/item_stall, a transfer happens when valid is
// high and stall is low. Results leave on result/result_valid/result_stall the same
// way. Registers are written on cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high. Write only while no item is in flight; the core does not enforce it.
// Throughput: one item per cycle while the skid register is empty. The depth is
// set by the 33-step square root and the (FRAC_BITS + 34)-step velocity divider,
// each of which retires one bit per stage, and by the split multiply.
// Reset: synchronous, empties the pipeline and loads the register defaults
// (inverse masses 1.0, rest length 1.0, time step 1092).
// Stall: a stalled result moves into the skid register while the pipeline still
// advances; while the skid register is full the whole pipeline holds and item_stall
// is high. Nothing is dropped or repeated.
module distance_constraint_impulse_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  dci_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output dci_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import dci_pkg::*;

  localparam int Q     = FRAC_BITS;
  localparam int NW    = Q + 1;          // unit vector / mass share width
  localparam int PW    = 33 + NW;        // |e| * share width
  localparam int WL    = 29;
  localparam int WH    = PW - WL;
  localparam int FW    = NW + PW;
  localparam int S_SUM = 2;
  localparam int S_LEN = S_SUM + 33;
  localparam int S_E   = S_LEN + 1;
  localparam int S_P   = S_E + 1;
  localparam int S_W   = S_P + PW;
  localparam int S_M1  = S_W + 1;
  localparam int S_M2  = S_W + 2;
  localparam int LAST  = S_W + 3;

  // configuration
  logic [31:0] inv_mass_a, inv_mass_b, time_step;
  logic [30:0] rest_length;
  logic [32:0] sum_inv;
  logic [31:0] dt;

  assign cfg_ready = 1'b1;
  assign sum_inv   = {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
  assign dt        = (time_step == 32'd0) ? 32'd1 : time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass_a  <= RST_INV_MASS;
      inv_mass_b  <= RST_INV_MASS;
      rest_length <= RST_REST_LEN;
      time_step   <= RST_TIME_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INV_MASS_A:  inv_mass_a  <= cfg_data;
        CFG_INV_MASS_B:  inv_mass_b  <= cfg_data;
        CFG_REST_LENGTH: rest_length <= cfg_data[30:0];
        CFG_TIME_STEP:   time_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic            skid_valid;
  result_t         skid;
  logic [LAST:0]   vld;

  assign en         = !skid_valid;
  assign item_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], item_valid};
    end
  end

  // carried payload
  logic [5:0][31:0] vel    [0:LAST];
  logic [2:0][31:0] mag    [0:S_LEN];
  logic [2:0]       dneg   [0:S_M2];
  logic             degen  [S_SUM:S_M2];
  logic [2:0][63:0] sq;
  logic             e_neg  [S_E:S_M2];
  logic [32:0]      abs_e;

  logic [2:0][32:0] d_in;
  logic [2:0][31:0] mag_in;
  logic [65:0]      sum;

  always_comb begin
    d_in[0] = {item.anchor_b_x[31], item.anchor_b_x} - {item.anchor_a_x[31], item.anchor_a_x};
    d_in[1] = {item.anchor_b_y[31], item.anchor_b_y} - {item.anchor_a_y[31], item.anchor_a_y};
    d_in[2] = {item.anchor_b_z[31], item.anchor_b_z} - {item.anchor_a_z[31], item.anchor_a_z};
    for (int c = 0; c < 3; c++) begin
      mag_in[c] = d_in[c][32] ? 32'(-d_in[c]) : d_in[c][31:0];
    end
    sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
  end

  logic [32:0] len_e;
  logic [33:0] e_full;

  always_ff @(posedge clk) begin
    if (en) begin
      vel[0] <= {item.vel_in_b_z, item.vel_in_b_y, item.vel_in_b_x,
                 item.vel_in_a_z, item.vel_in_a_y, item.vel_in_a_x};
      for (int s = 1; s <= LAST; s++) vel[s] <= vel[s-1];
      mag[0] <= mag_in;
      for (int s = 1; s <= S_LEN; s++) mag[s] <= mag[s-1];
      dneg[0] <= {d_in[2][32], d_in[1][32], d_in[0][32]};
      for (int s = 1; s <= S_M2; s++) dneg[s] <= dneg[s-1];
      for (int c = 0; c < 3; c++) sq[c] <= mag[0][c] * mag[0][c];
      degen[S_SUM] <= (sum == 66'd0) || (sum_inv == 33'd0);
      for (int s = S_SUM + 1; s <= S_M2; s++) degen[s] <= degen[s-1];
      e_neg[S_E] <= e_full[33];
      for (int s = S_E + 1; s <= S_M2; s++) e_neg[s] <= e_neg[s-1];
      abs_e <= e_full[33] ? 33'(-e_full) : e_full[32:0];
    end
  end

  // square root, one root bit per stage
  logic [65:0] rad       [S_SUM:S_LEN];
  logic [33:0] srem      [S_SUM:S_LEN];
  logic [32:0] root      [S_SUM:S_LEN];
  logic [65:0] rad_next  [S_SUM:S_LEN];
  logic [33:0] srem_next [S_SUM:S_LEN];
  logic [32:0] root_next [S_SUM:S_LEN];

  assign e_full = {1'b0, root[S_LEN]} - {3'b000, rest_length};

  always_comb begin
    logic [35:0] t, trial;
    rad_next[S_SUM]  = sum;
    srem_next[S_SUM] = '0;
    root_next[S_SUM] = '0;
    for (int s = S_SUM + 1; s <= S_LEN; s++) begin
      t     = {srem[s-1], rad[s-1][65:64]};
      trial = {1'b0, root[s-1], 2'b01};
      rad_next[s] = {rad[s-1][63:0], 2'b00};
      if (t >= trial) begin
        srem_next[s] = 34'(t - trial);
        root_next[s] = {root[s-1][31:0], 1'b1};
      end else begin
        srem_next[s] = t[33:0];
        root_next[s] = {root[s-1][31:0], 1'b0};
      end
    end
  end

  // mass share dividers, running beside the root
  logic [1:0][32:0]   shr      [S_SUM:S_E];
  logic [1:0][NW-1:0] shq      [S_SUM:S_E];
  logic [1:0][32:0]   shr_next [S_SUM:S_E];
  logic [1:0][NW-1:0] shq_next [S_SUM:S_E];

  always_comb begin
    logic [33:0] t;
    shr_next[S_SUM][0] = {2'b00, inv_mass_a[31:1]};
    shq_next[S_SUM][0] = {inv_mass_a[0], {Q{1'b0}}};
    shr_next[S_SUM][1] = {2'b00, inv_mass_b[31:1]};
    shq_next[S_SUM][1] = {inv_mass_b[0], {Q{1'b0}}};
    for (int s = S_SUM + 1; s <= S_E; s++) begin
      for (int l = 0; l < 2; l++) begin
        t = {shr[s-1][l], shq[s-1][l][NW-1]};
        if (s > S_SUM + NW) begin
          shr_next[s][l] = shr[s-1][l];
          shq_next[s][l] = shq[s-1][l];
        end else if (t >= {1'b0, sum_inv}) begin
          shr_next[s][l] = 33'(t - {1'b0, sum_inv});
          shq_next[s][l] = {shq[s-1][l][NW-2:0], 1'b1};
        end else begin
          shr_next[s][l] = t[32:0];
          shq_next[s][l] = {shq[s-1][l][NW-2:0], 1'b0};
        end
      end
    end
  end

  // unit vector dividers
  logic [2:0][32:0]   nr        [S_E:S_W];
  logic [2:0][NW-1:0] nq        [S_E:S_W];
  logic [32:0]        lenq      [S_E:S_W];
  logic [2:0][32:0]   nr_next   [S_E:S_W];
  logic [2:0][NW-1:0] nq_next   [S_E:S_W];
  logic [32:0]        lenq_next [S_E:S_W];

  assign len_e = root[S_LEN];

  always_comb begin
    logic [33:0] t;
    lenq_next[S_E] = len_e;
    for (int c = 0; c < 3; c++) begin
      nr_next[S_E][c] = {2'b00, mag[S_LEN][c][31:1]};
      nq_next[S_E][c] = {mag[S_LEN][c][0], {Q{1'b0}}};
    end
    for (int s = S_E + 1; s <= S_W; s++) begin
      lenq_next[s] = lenq[s-1];
      for (int c = 0; c < 3; c++) begin
        t = {nr[s-1][c], nq[s-1][c][NW-1]};
        if (s >= S_P + NW) begin
          nr_next[s][c] = nr[s-1][c];
          nq_next[s][c] = nq[s-1][c];
        end else if (t >= {1'b0, lenq[s-1]}) begin
          nr_next[s][c] = 33'(t - {1'b0, lenq[s-1]});
          nq_next[s][c] = {nq[s-1][c][NW-2:0], 1'b1};
        end else begin
          nr_next[s][c] = t[32:0];
          nq_next[s][c] = {nq[s-1][c][NW-2:0], 1'b0};
        end
      end
    end
  end

  // velocity magnitude: |e| * share / dt
  logic [1:0][31:0]   wr      [S_P:S_W];
  logic [1:0][PW-1:0] wq      [S_P:S_W];
  logic [1:0][31:0]   wr_next [S_P:S_W];
  logic [1:0][PW-1:0] wq_next [S_P:S_W];

  always_comb begin
    logic [32:0] t;
    for (int l = 0; l < 2; l++) begin
      wr_next[S_P][l] = '0;
      wq_next[S_P][l] = abs_e * shq[S_E][l];
    end
    for (int s = S_P + 1; s <= S_W; s++) begin
      for (int l = 0; l < 2; l++) begin
        t = {wr[s-1][l], wq[s-1][l][PW-1]};
        if (t >= {1'b0, dt}) begin
          wr_next[s][l] = 32'(t - {1'b0, dt});
          wq_next[s][l] = {wq[s-1][l][PW-2:0], 1'b1};
        end else begin
          wr_next[s][l] = t[31:0];
          wq_next[s][l] = {wq[s-1][l][PW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = S_SUM; s <= S_LEN; s++) begin
        rad[s]  <= rad_next[s];
        srem[s] <= srem_next[s];
        root[s] <= root_next[s];
      end
      for (int s = S_SUM; s <= S_E; s++) begin
        shr[s] <= shr_next[s];
        shq[s] <= shq_next[s];
      end
      for (int s = S_E; s <= S_W; s++) begin
        nr[s]   <= nr_next[s];
        nq[s]   <= nq_next[s];
        lenq[s] <= lenq_next[s];
      end
      for (int s = S_P; s <= S_W; s++) begin
        wr[s] <= wr_next[s];
        wq[s] <= wq_next[s];
      end
    end
  end

  // split multiply n * w, then shift, cap and apply
  logic [1:0][2:0][NW+WL-1:0] pl;
  logic [1:0][2:0][NW+WH-1:0] ph;
  logic [1:0][2:0][40:0]      delta;
  logic [1:0][2:0][40:0]      delta_next;
  result_t                    res;
  result_t                    res_next;
  logic [5:0][31:0]           vout;

  always_comb begin
    logic [FW-1:0] full;
    logic [FW-1:0] sh;
    for (int l = 0; l < 2; l++) begin
      for (int c = 0; c < 3; c++) begin
        full = (FW'(ph[l][c]) << WL) + FW'(pl[l][c]);
        sh   = full >> Q;
        delta_next[l][c] = (sh > FW'(DELTA_CAP)) ? DELTA_CAP : sh[40:0];
      end
    end
  end

  always_comb begin
    logic [42:0] v, dd, r;
    logic        neg;
    for (int l = 0; l < 2; l++) begin
      for (int c = 0; c < 3; c++) begin
        v   = {{11{vel[S_M2][3*l+c][31]}}, vel[S_M2][3*l+c]};
        dd  = {2'b00, delta[l][c]};
        neg = (dneg[S_M2][c] != e_neg[S_M2]) != (l == 1);
        r   = neg ? v - dd : v + dd;
        if (degen[S_M2]) begin
          vout[3*l+c] = vel[S_M2][3*l+c];
        end else if (!r[42] && (|r[41:31])) begin
          vout[3*l+c] = 32'h7FFF_FFFF;
        end else if (r[42] && !(&r[41:31])) begin
          vout[3*l+c] = 32'h8000_0000;
        end else begin
          vout[3*l+c] = r[31:0];
        end
      end
    end
    res_next.vel_out_a_x = vout[0];
    res_next.vel_out_a_y = vout[1];
    res_next.vel_out_a_z = vout[2];
    res_next.vel_out_b_x = vout[3];
    res_next.vel_out_b_y = vout[4];
    res_next.vel_out_b_z = vout[5];
    res_next.degenerate  = degen[S_M2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        for (int c = 0; c < 3; c++) begin
          pl[l][c] <= nq[S_W][c] * wq[S_W][l][WL-1:0];
          ph[l][c] <= nq[S_W][c] * wq[S_W][l][PW-1:WL];
        end
      end
      delta <= delta_next;
      res   <= res_next;
    end
  end

  // output skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!result_stall) skid_valid <= 1'b0;
    end else if (vld[LAST] && result_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vld[LAST] && result_stall) skid <= res;
  end

  assign result_valid = skid_valid || vld[LAST];
  assign result       = skid_valid ? skid : res;

  // checks
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && !skid_valid && result_stall |=> skid_valid)
    else $error("stalled result not caught by skid register");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> vld[0])
    else $error("accepted item missing from first stage");

  a_degen_pass: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && res.degenerate |-> res.vel_out_a_x == vel[LAST][0] &&
    res.vel_out_b_z == vel[LAST][5])
    else $error("degenerate item changed velocity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(res) || !$past(skid_valid))
    else $error("pipeline moved while skid register full");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the distance constraint impulse core.
`timescale 1ns / 1ps

module tb_top;
  import dci_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE = 120;
  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  item_t pending_items[$];
  result_t expected_vel[$];
  logic [31:0] mass_a = RST_INV_MASS;
  logic [31:0] mass_b = RST_INV_MASS;
  logic [30:0] rest_len = RST_REST_LEN;
  logic [31:0] step_dt = RST_TIME_STEP;
  logic gaps_on = 1'b1;
  logic long_hold = 1'b0;
  int item_gap = 0;
  int result_gap = 0;
  int errors = 0;
  int cycles = 0;

  distance_constraint_impulse_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] isqrt66(logic [65:0] x);
    logic [69:0] rem;
    logic [69:0] trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 70'(x[2*i +: 2]);
      trial = (70'(root) << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic result_t predict_impulse(item_t it);
    logic signed [31:0] pa[3];
    logic signed [31:0] pb[3];
    logic signed [31:0] vin[6];
    logic [31:0] vout[6];
    longint d[3];
    logic [32:0] mag[3];
    logic [65:0] sq;
    logic [33:0] sum_inv;
    logic [63:0] len, share, w, n, abs_e, dt, delta, inv;
    logic [127:0] prod;
    longint e, v;
    logic e_neg, neg;
    result_t r;
    pa = '{it.anchor_a_x, it.anchor_a_y, it.anchor_a_z};
    pb = '{it.anchor_b_x, it.anchor_b_y, it.anchor_b_z};
    vin = '{it.vel_in_a_x, it.vel_in_a_y, it.vel_in_a_z,
            it.vel_in_b_x, it.vel_in_b_y, it.vel_in_b_z};
    sq = '0;
    for (int c = 0; c < 3; c++) begin
      d[c] = longint'(pb[c]) - longint'(pa[c]);
      mag[c] = (d[c] < 0) ? 33'(-d[c]) : 33'(d[c]);
      sq = sq + 66'(mag[c]) * 66'(mag[c]);
    end
    for (int k = 0; k < 6; k++) vout[k] = vin[k];
    sum_inv = 34'(mass_a) + 34'(mass_b);
    r.degenerate = (sq == 0) || (sum_inv == 0);
    if (!r.degenerate) begin
      len = isqrt66(sq);
      e = longint'(len) - longint'(rest_len);
      e_neg = e < 0;
      abs_e = e_neg ? 64'(-e) : 64'(e);
      dt = (step_dt == 0) ? 64'd1 : 64'(step_dt);
      for (int body = 0; body < 2; body++) begin
        inv = body ? 64'(mass_b) : 64'(mass_a);
        share = (inv << FRAC) / 64'(sum_inv);
        w = (abs_e * share) / dt;
        for (int c = 0; c < 3; c++) begin
          n = (64'(mag[c]) << FRAC) / len;
          prod = 128'(n) * 128'(w);
          if ((prod >> FRAC) > 128'(DELTA_CAP)) delta = 64'(DELTA_CAP);
          else delta = 64'(prod >> FRAC);
          neg = ((d[c] < 0) != e_neg) != (body != 0);
          v = longint'(vin[3*body + c]);
          v = neg ? v - longint'(delta) : v + longint'(delta);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          vout[3*body + c] = v[31:0];
        end
      end
    end
    r.vel_out_a_x = vout[0]; r.vel_out_a_y = vout[1]; r.vel_out_a_z = vout[2];
    r.vel_out_b_x = vout[3]; r.vel_out_b_y = vout[4]; r.vel_out_b_z = vout[5];
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item_gap <= 0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) expected_vel.push_back(predict_impulse(item));
      if (item_gap > 0) begin
        item_gap <= item_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        item_gap <= gaps_on ? $urandom_range(0, 13) : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    int gap_n;
    gap_n = (result_gap > 0) ? result_gap - 1 : 0;
    if (rst) begin
      result_stall <= 1'b0;
      result_gap <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_vel.size() == 0) begin
          $display("unexpected result transfer at cycle %0d", cycles);
          errors++;
        end else begin
          want = expected_vel.pop_front();
          if (result.vel_out_a_x !== want.vel_out_a_x)
            report("vel_out_a_x", result.vel_out_a_x, want.vel_out_a_x);
          if (result.vel_out_a_y !== want.vel_out_a_y)
            report("vel_out_a_y", result.vel_out_a_y, want.vel_out_a_y);
          if (result.vel_out_a_z !== want.vel_out_a_z)
            report("vel_out_a_z", result.vel_out_a_z, want.vel_out_a_z);
          if (result.vel_out_b_x !== want.vel_out_b_x)
            report("vel_out_b_x", result.vel_out_b_x, want.vel_out_b_x);
          if (result.vel_out_b_y !== want.vel_out_b_y)
            report("vel_out_b_y", result.vel_out_b_y, want.vel_out_b_y);
          if (result.vel_out_b_z !== want.vel_out_b_z)
            report("vel_out_b_z", result.vel_out_b_z, want.vel_out_b_z);
          if (result.degenerate !== want.degenerate)
            report("degenerate", 32'(result.degenerate), 32'(want.degenerate));
        end
        gap_n = gaps_on ? $urandom_range(0, 13) : 0;
      end
      result_gap <= gap_n;
      result_stall <= long_hold || (gap_n > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[distance_constraint_impulse_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INV_MASS_A: mass_a = val;
      CFG_INV_MASS_B: mass_b = val;
      CFG_REST_LENGTH: rest_len = val[30:0];
      CFG_TIME_STEP: step_dt = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] ma, logic [31:0] mb, logic [31:0] rl, logic [31:0] dt);
    write_reg(CFG_INV_MASS_A, ma);
    write_reg(CFG_INV_MASS_B, mb);
    write_reg(CFG_REST_LENGTH, rl);
    write_reg(CFG_TIME_STEP, dt);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || item_valid || expected_vel.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    int mode;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(0, 3);
    // mostly nearby anchors so the error term stays in a useful range
    if (mode != 0) begin
      it.anchor_b_x = it.anchor_a_x + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      it.anchor_b_y = it.anchor_a_y + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      it.anchor_b_z = it.anchor_a_z + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    if (mode == 2) begin
      it.vel_in_a_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      it.vel_in_b_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    if (mode == 3 && $urandom_range(0, 3) == 0) begin
      it.anchor_b_x = it.anchor_a_x;
      it.anchor_b_y = it.anchor_a_y;
      it.anchor_b_z = it.anchor_a_z;
    end
    return it;
  endfunction

  task automatic push_random(int count);
    repeat (count) pending_items.push_back(rand_item());
  endtask

  task automatic push_directed();
    item_t it;
    logic signed [31:0] mx;
    logic signed [31:0] mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    it = '0;
    pending_items.push_back(it);                       // zero separation
    it.anchor_b_x = 32'sd65536;                        // exactly at rest length
    pending_items.push_back(it);
    it.anchor_b_x = 32'sd196608;                       // stretched
    pending_items.push_back(it);
    it.anchor_b_x = -32'sd16384;                       // compressed, negative axis
    pending_items.push_back(it);
    it = '{mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn};  // widest separation
    pending_items.push_back(it);
    it = '{mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx};
    pending_items.push_back(it);
    it = '{0, 0, 0, 32'sd1, 0, 0, mx, mn, 0, mn, mx, 0};     // tiny separation
    pending_items.push_back(it);
    it = '{32'sd100, 32'sd200, 32'sd300, 32'sd100, 32'sd200, 32'sd300,
           mx, mx, mx, mn, mn, mn};                          // zero separation, extreme vel
    pending_items.push_back(it);
    it = '{0, 0, 0, 32'sd1000000, -32'sd1000000, 32'sd5, mx, mn, mx, mn, mx, mn};
    pending_items.push_back(it);
    it = '1;
    pending_items.push_back(it);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_directed();
    push_random(PHASE_ITEMS - 10);
    wait_drained();

    set_regs(32'd65536, 32'd65536, 32'd196608, 32'd1092);
    write_reg(CFG_SPARE_LO, 32'hDEADBEEF);   // ignored indexes
    write_reg(CFG_SPARE_HI, 32'h00000000);
    push_directed();
    push_random(PHASE_ITEMS);
    wait_drained();

    set_regs(32'd0, 32'd0, 32'd65536, 32'd1092);   // both bodies immovable
    push_directed();
    push_random(40);
    wait_drained();

    set_regs(32'd0, 32'd1 << 20, 32'd0, 32'd0);    // one immovable, zero step
    push_directed();
    push_random(PHASE_ITEMS);
    wait_drained();

    set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    push_directed();
    push_random(PHASE_ITEMS);
    wait_drained();

    set_regs($urandom, $urandom, $urandom, $urandom);
    push_random(PHASE_ITEMS);
    wait_drained();

    // long receiver hold-off while items keep coming, fills the pipeline
    set_regs(32'd1, 32'd262144, 32'd1 << 20, 32'd65536);
    gaps_on = 1'b0;
    push_random(PHASE_ITEMS + 60);
    fork
      begin
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    wait_drained();

    gaps_on = 1'b1;
    set_regs($urandom, $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 22),
             $urandom_range(1, 1 << 12));
    push_random(PHASE_ITEMS);
    wait_drained();

    gaps_on = 1'b0;
    set_regs($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17),
             $urandom_range(0, 1 << 20), $urandom_range(1, 1 << 16));
    push_random(PHASE_ITEMS);
    wait_drained();

    if (errors == 0) begin
      $display("[distance_constraint_impulse_core] OK");
    end else begin
      $display("[distance_constraint_impulse_core] ERROR");
    end
    $finish;
  end

endmodule
